[src/fgm_pkg.sv]
// Shared types and constants for the Fibonacci-of-GCD modulo unit.
package fgm_pkg;

    localparam int unsigned DATA_W = 32;
    localparam logic [DATA_W-1:0] MODULUS_RESET = 32'd100000000;
    localparam logic [DATA_W-1:0] ADDR_MODULUS = 32'd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GCD,
        ST_GCD_WAIT,
        ST_CHECK,
        ST_MUL_START,
        ST_MUL_WAIT,
        ST_NEXT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        DP_NONE,
        DP_LOAD,
        DP_GCD_STEP,
        DP_MAT_INIT
    } t_dp_op;

    // Controller to datapath commands.
    typedef struct packed {
        t_dp_op op;
        logic   mul_start;  // start a matrix multiply
        logic   mul_acc;    // 1: acc = acc*base, 0: base = base*base
        logic   shift_exp;  // shift exponent one bit
        logic   emit;       // drive a result
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic gcd_done;     // divisor is zero
        logic div_busy;
        logic small_g;      // g <= 2
        logic exp_zero;
        logic exp_lsb;
        logic mul_busy;
    } t_status;

endpackage

[src/fgm_modmul.sv]
// Sequential modular multiplier: shift-add, one multiplier bit per cycle.
module fgm_modmul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [fgm_pkg::DATA_W-1:0] i_a,
    input  logic [fgm_pkg::DATA_W-1:0] i_b,
    input  logic [fgm_pkg::DATA_W:0]   i_m,
    output logic                      o_busy,
    output logic [fgm_pkg::DATA_W-1:0] o_p
);
    import fgm_pkg::*;

    logic [DATA_W:0]   r_acc, n_acc;
    logic [DATA_W:0]   r_a, n_a;
    logic [DATA_W-1:0] r_b, n_b;
    logic [5:0]        r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic [DATA_W+1:0] dbl, sum, sum2;

    // Interleaved multiplication: acc = 2*acc + a*bit, reduced each step.
    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        dbl    = {r_acc, 1'b0};
        if (dbl >= {1'b0, i_m}) begin
            dbl = dbl - {1'b0, i_m};
        end
        sum = dbl + (r_b[DATA_W-1] ? {1'b0, r_a} : '0);
        sum2 = sum;
        if (sum2 >= {1'b0, i_m}) begin
            sum2 = sum2 - {1'b0, i_m};
        end
        if (i_start) begin
            n_acc  = '0;
            n_a    = {1'b0, i_a};
            n_b    = i_b;
            n_cnt  = 6'(DATA_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = sum2[DATA_W:0];
            n_b   = {r_b[DATA_W-2:0], 1'b0};
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_busy = r_busy;
    assign o_p    = r_acc[DATA_W-1:0];

endmodule

[src/fgm_divider.sv]
// Restoring divider that returns the remainder, one quotient bit per cycle.
module fgm_divider #(
    parameter int unsigned W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_busy,
    output logic [W-1:0] o_rem
);
    import fgm_pkg::*;

    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_num, n_num;
    logic [W-1:0]  r_den, n_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic [W:0]    trial;

    always_comb begin
        n_rem  = r_rem;
        n_num  = r_num;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        trial  = {r_rem, r_num[W-1]};
        if (i_start) begin
            n_rem  = '0;
            n_num  = i_num;
            n_den  = i_den;
            n_cnt  = CW'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                trial = trial - {1'b0, r_den};
            end
            n_rem = trial[W-1:0];
            n_num = {r_num[W-2:0], 1'b0};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_num <= n_num;
        r_den <= n_den;
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

[src/fgm_datapath.sv]
// Datapath: Euclid registers, exponent, 2x2 matrices and arithmetic units.
module fgm_datapath #(
    parameter int unsigned INDEX_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fgm_pkg::t_cmd              i_cmd,
    input  logic [INDEX_WIDTH-1:0]     i_a,
    input  logic [INDEX_WIDTH-1:0]     i_b,
    input  logic [fgm_pkg::DATA_W-1:0] i_modulus,
    output fgm_pkg::t_status           o_status,
    output logic [fgm_pkg::DATA_W-1:0] o_result
);
    import fgm_pkg::*;

    logic [INDEX_WIDTH-1:0] r_ga, r_gb, r_exp;
    logic [DATA_W-1:0]      r_acc [4];
    logic [DATA_W-1:0]      r_base [4];
    logic [DATA_W-1:0]      r_tmp [4];
    logic [DATA_W-1:0]      r_p0;
    logic [2:0]             r_step;
    logic                   r_mul_acc;
    logic                   r_mbusy;
    logic                   r_issue;
    logic                   r_gb_pending;
    logic [DATA_W:0]        mod_w;
    logic [DATA_W-1:0]      one_m;
    logic                   div_busy, mul_busy, mul_start;
    logic                   mul_done;
    logic                   sel_acc;
    logic [INDEX_WIDTH-1:0] rem;
    logic [DATA_W-1:0]      prod, ma, mb;
    logic [DATA_W:0]        psum;
    logic [DATA_W-1:0]      psum_m;
    logic                   div_start;
    logic [1:0]             ia, ja;

    assign mod_w = (i_modulus == '0) ? {1'b1, {DATA_W{1'b0}}} : {1'b0, i_modulus};
    assign one_m = (i_modulus == DATA_W'(1)) ? '0 : DATA_W'(1);
    assign div_start = (i_cmd.op == DP_LOAD) ? 1'b0 : (i_cmd.op == DP_GCD_STEP);

    fgm_divider #(.W(INDEX_WIDTH)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_ga),
        .i_den   (r_gb),
        .o_busy  (div_busy),
        .o_rem   (rem)
    );

    // Eight products per matrix multiply; step = 2*entry + term.
    // The first product starts with the command, before r_mul_acc is loaded.
    assign sel_acc = i_cmd.mul_start ? i_cmd.mul_acc : r_mul_acc;
    assign ia = {1'b0, r_step[2]};
    assign ja = {1'b0, r_step[1]};
    always_comb begin
        if (!r_step[0]) begin
            ma = sel_acc ? r_acc[{ia[0], 1'b0}] : r_base[{ia[0], 1'b0}];
            mb = r_base[{1'b0, ja[0]}];
        end else begin
            ma = sel_acc ? r_acc[{ia[0], 1'b1}] : r_base[{ia[0], 1'b1}];
            mb = r_base[{1'b1, ja[0]}];
        end
    end

    // A product is taken when the multiplier goes idle; the next product is
    // issued in the following cycle, once the step has advanced.
    assign mul_done  = r_mbusy && !mul_busy && !r_issue;
    assign mul_start = i_cmd.mul_start || r_issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
        end else begin
            r_issue <= mul_done && (r_step != 3'd7);
        end
    end

    fgm_modmul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (ma),
        .i_b     (mb),
        .i_m     (mod_w),
        .o_busy  (mul_busy),
        .o_p     (prod)
    );

    assign psum   = {1'b0, r_p0} + {1'b0, prod};
    assign psum_m = (psum >= mod_w) ? DATA_W'(psum - mod_w) : psum[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_step  <= '0;
        end else if (i_cmd.mul_start) begin
            r_mbusy   <= 1'b1;
            r_step    <= '0;
            r_mul_acc <= i_cmd.mul_acc;
        end else if (mul_done) begin
            if (!r_step[0]) begin
                r_p0 <= prod;
            end else begin
                r_tmp[r_step[2:1]] <= psum_m;
            end
            r_step <= r_step + 3'd1;
            if (r_step == 3'd7) begin
                r_mbusy <= 1'b0;
            end
        end
        if (mul_done && r_step == 3'd7) begin
            for (int k = 0; k < 4; k++) begin
                if (r_mul_acc) begin
                    r_acc[k] <= (k == 3) ? psum_m : r_tmp[k];
                end else begin
                    r_base[k] <= (k == 3) ? psum_m : r_tmp[k];
                end
            end
        end
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_ga <= i_a;
                r_gb <= i_b;
            end
            DP_GCD_STEP: begin
                r_ga <= r_gb;
            end
            DP_MAT_INIT: begin
                r_exp     <= r_ga - INDEX_WIDTH'(1);
                r_acc[0]  <= one_m;
                r_acc[1]  <= '0;
                r_acc[2]  <= '0;
                r_acc[3]  <= one_m;
                r_base[0] <= one_m;
                r_base[1] <= one_m;
                r_base[2] <= one_m;
                r_base[3] <= '0;
            end
            default: begin
            end
        endcase
        if (i_cmd.op == DP_NONE && !div_busy && r_gb_pending) begin
            r_gb <= rem;
        end
        if (i_cmd.shift_exp) begin
            r_exp <= r_exp >> 1;
        end
    end

    // Remainder lands in gb once the divider finishes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gb_pending <= 1'b0;
        end else if (i_cmd.op == DP_GCD_STEP) begin
            r_gb_pending <= 1'b1;
        end else if (!div_busy) begin
            r_gb_pending <= 1'b0;
        end
    end

    assign o_status.gcd_done = (r_gb == '0);
    assign o_status.div_busy = div_busy || r_gb_pending;
    assign o_status.small_g  = (r_ga <= INDEX_WIDTH'(2));
    assign o_status.exp_zero = (r_exp == '0);
    assign o_status.exp_lsb  = r_exp[0];
    assign o_status.mul_busy = r_mbusy;
    assign o_result = o_status.small_g ? one_m : r_acc[0];

endmodule

[src/fgm_ctrl.sv]
// Controller state machine sequencing Euclid and matrix exponentiation.
module fgm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  fgm_pkg::t_status i_status,
    output fgm_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_valid
);
    import fgm_pkg::*;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_start) n_state = ST_GCD;
            ST_GCD: begin
                if (i_status.gcd_done) begin
                    n_state = ST_CHECK;
                end else begin
                    n_state = ST_GCD_WAIT;
                end
            end
            ST_GCD_WAIT:  if (!i_status.div_busy) n_state = ST_GCD;
            ST_CHECK:     n_state = i_status.small_g ? ST_DONE : ST_NEXT;
            ST_NEXT:      n_state = i_status.exp_zero ? ST_DONE : ST_MUL_START;
            ST_MUL_START: n_state = ST_MUL_WAIT;
            ST_MUL_WAIT:  if (!i_status.mul_busy) n_state = ST_NEXT;
            ST_DONE:      n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // The multiply phase alternates: odd exponent bit does acc*base first,
    // then base*base with an exponent shift.
    logic r_sq_pending;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_sq_pending <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_MUL_START) begin
                r_sq_pending <= !r_sq_pending && i_status.exp_lsb;
            end else if (r_state == ST_CHECK) begin
                r_sq_pending <= 1'b0;
            end
        end
    end

    always_comb begin
        o_cmd = '{op: DP_NONE, mul_start: 1'b0, mul_acc: 1'b0,
                  shift_exp: 1'b0, emit: 1'b0};
        unique case (r_state)
            ST_IDLE:  if (i_start) o_cmd.op = DP_LOAD;
            ST_GCD:   if (!i_status.gcd_done) o_cmd.op = DP_GCD_STEP;
            ST_CHECK: o_cmd.op = DP_MAT_INIT;
            ST_MUL_START: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_acc   = !r_sq_pending && i_status.exp_lsb;
                o_cmd.shift_exp = !(!r_sq_pending && i_status.exp_lsb);
            end
            ST_DONE:  o_cmd.emit = 1'b1;
            default: begin
            end
        endcase
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = o_cmd.emit;

    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> (r_state == ST_IDLE)) else $error("done held");
    a_no_dual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.mul_start && o_cmd.op != DP_NONE)) else $error("cmd clash");
    a_start_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == ST_IDLE) |=> (r_state == ST_GCD)) else $error("start");

endmodule

[src/fibonacci_of_gcd_mod_unit.sv]
// Top level of the Fibonacci-of-GCD modulo unit with its APB register.
// Euclid runs one divider pass per remainder step; then each exponent bit
// takes one or two matrix multiplies of eight products each.
// Throughput: one item at a time; busy stays high until the result strobe.
// The result is on o_fib_mod for exactly one cycle with o_done; it cannot stall.
// Synchronous active-low reset returns the controller to idle and the modulus
// register to 100000000.
module fibonacci_of_gcd_mod_unit #(
    parameter int unsigned INDEX_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [INDEX_WIDTH-1:0] i_first_index,
    input  logic [INDEX_WIDTH-1:0] i_second_index,
    output logic                   o_done,
    output logic [31:0]            o_fib_mod,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic                   paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import fgm_pkg::*;

    t_cmd              cmd;
    t_status           status;
    logic [DATA_W-1:0] r_modulus;
    logic              wr_en;

    // The single register sits at byte address zero; paddr is one bit wide.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign prdata = paddr ? '0 : r_modulus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET;
        end else if (wr_en && !paddr) begin
            r_modulus <= pwdata;
        end
    end

    fgm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_done)
    );

    fgm_datapath #(.INDEX_WIDTH(INDEX_WIDTH)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_a       (i_first_index),
        .i_b       (i_second_index),
        .i_modulus (r_modulus),
        .o_status  (status),
        .o_result  (o_fib_mod)
    );

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("done while idle");
    a_mod_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !(psel && penable && pwrite)) |=> $stable(r_modulus))
        else $error("modulus changed");
    a_rdy: assert property (@(posedge i_clk) pready) else $error("pready low");

endmodule

[test/testbench.sv]
// Self-checking testbench for the Fibonacci-of-GCD modulo unit.
`timescale 1ns / 1ps

module testbench;
    import fgm_pkg::*;

    // The slowest item takes about 48 Euclid steps plus 64 matrix multiplies.
    // The limit covers every item at that worst case, with its sender gap,
    // several times over.
    localparam longint unsigned CYCLE_LIMIT = 100_000_000;
    localparam int unsigned RANDOM_ITEMS = 1400;
    localparam int unsigned DRAIN_CYCLES = 64;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_first_index;
    logic [31:0] i_second_index;
    logic        o_done;
    logic [31:0] o_fib_mod;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic        paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // This is the software copy of the modulus register. Zero stands for 2^32.
    logic [31:0] modulus_shadow;
    // These are the Fibonacci residues still owed by the unit, oldest first.
    logic [31:0] fib_results_due[$];
    int unsigned error_count;
    longint unsigned cycle_count;

    fibonacci_of_gcd_mod_unit #(.INDEX_WIDTH(32)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_first_index(i_first_index),
        .i_second_index(i_second_index),
        .o_done(o_done),
        .o_fib_mod(o_fib_mod),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // The product of two 2x2 matrices, each entry reduced modulo m. Every
    // entry is below m, which is at most 2^32, so each product fits 64 bits.
    function automatic logic [3:0][63:0] mat_product(logic [3:0][63:0] x,
                                                     logic [3:0][63:0] y,
                                                     logic [63:0] m);
        logic [3:0][63:0] prod;
        logic [63:0] p0;
        logic [63:0] p1;
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                p0 = (x[i*2] * y[j]) % m;
                p1 = (x[i*2+1] * y[2+j]) % m;
                prod[i*2+j] = (p0 + p1) % m;
            end
        end
        return prod;
    endfunction

    // F(gcd(a, b)) modulo the modulus, by Euclid and then by raising the
    // matrix [[1,1],[1,0]] to the power g-1, one exponent bit per round.
    function automatic logic [31:0] fib_of_gcd(logic [31:0] a_in, logic [31:0] b_in,
                                               logic [31:0] mod_reg);
        logic [63:0] m;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        logic [63:0] e;
        logic [3:0][63:0] acc;
        logic [3:0][63:0] base;
        m = (mod_reg == 32'd0) ? 64'h1_0000_0000 : {32'd0, mod_reg};
        a = {32'd0, a_in};
        b = {32'd0, b_in};
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        if (a <= 2) begin
            return 32'(64'd1 % m);
        end
        acc[0] = 64'd1 % m;
        acc[1] = 0;
        acc[2] = 0;
        acc[3] = 64'd1 % m;
        base[0] = 64'd1 % m;
        base[1] = 64'd1 % m;
        base[2] = 64'd1 % m;
        base[3] = 0;
        e = a - 1;
        while (e != 0) begin
            if (e[0]) begin
                acc = mat_product(acc, base, m);
            end
            e = e >> 1;
            base = mat_product(base, base, m);
        end
        return acc[0][31:0];
    endfunction

    // Every result strobe is compared with the oldest residue still owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (fib_results_due.size() == 0) begin
                $display("%0t: result 0x%08h with no item outstanding", $time, o_fib_mod);
                error_count++;
            end else begin
                if (o_fib_mod !== fib_results_due[0]) begin
                    $display("%0t: fib_mod expected 0x%08h actual 0x%08h",
                             $time, fib_results_due[0], o_fib_mod);
                    error_count++;
                end
                void'(fib_results_due.pop_front());
            end
        end
    end

    // The watchdog ends a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Presents one item and returns at the edge that accepts it. The start
    // line is left high so that a burst can follow without a bubble.
    task automatic send_item(logic [31:0] first, logic [31:0] second);
        start <= 1'b1;
        i_first_index <= first;
        i_second_index <= second;
        do @(posedge i_clk); while (busy);
        fib_results_due.push_back(fib_of_gcd(first, second, modulus_shadow));
    endtask

    task automatic idle_cycles(int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Waits until every owed result has come and the unit has gone idle.
    task automatic drain_unit();
        start <= 1'b0;
        @(posedge i_clk);
        while (fib_results_due.size() != 0 || busy) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One APB write followed by a read of the same address. Only address 0
    // holds a register; the other address ignores writes.
    task automatic write_register(logic addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_MODULUS[0]) begin
            modulus_shadow = value;
        end
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_MODULUS[0] && prdata !== modulus_shadow) begin
            $display("%0t: modulus readback expected 0x%08h actual 0x%08h",
                     $time, modulus_shadow, prdata);
            error_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Builds a random pair. Most pairs are multiples of a chosen divisor so
    // that the matrix power gets real work; a few use a large divisor.
    task automatic random_pair(output logic [31:0] first, output logic [31:0] second);
        logic [31:0] g;
        logic [31:0] span;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            first = $urandom();
            second = $urandom();
        end else begin
            if (pick < 85) begin
                g = $urandom_range(1, 1000);
            end else if (pick < 96) begin
                g = $urandom_range(1000, 1 << 20);
            end else begin
                g = $urandom_range(1 << 20, 32'hFFFF_FFFF);
            end
            span = 32'hFFFF_FFFF / g;
            first = g * $urandom_range(1, span);
            second = g * $urandom_range(1, span);
        end
    endtask

    // Items in bursts of random length with random gaps; some bursts run
    // back to back with no gap at all.
    task automatic random_burst_run(int unsigned count);
        logic [31:0] first;
        logic [31:0] second;
        int unsigned burst;
        while (count > 0) begin
            burst = $urandom_range(1, 16);
            if (burst > count) burst = count;
            repeat (burst) begin
                random_pair(first, second);
                send_item(first, second);
            end
            count -= burst;
            if ($urandom_range(0, 3) != 0) begin
                idle_cycles($urandom_range(1, 8));
            end
        end
    endtask

    // Index extremes, the zero indices, g at the boundary of the trivial
    // case, and consecutive Fibonacci numbers, which make Euclid's longest run.
    task automatic test_directed_indices();
        send_item(32'd1, 32'd1);
        send_item(32'd2, 32'd2);
        send_item(32'd3, 32'd3);
        send_item(32'd0, 32'd0);
        send_item(32'd0, 32'd12);
        send_item(32'd25, 32'd0);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'd1);
        send_item(32'h8000_0000, 32'h8000_0000);
        send_item(32'h8000_0000, 32'hC000_0000);
        send_item(32'd2971215073, 32'd1836311903);
        send_item(32'd6, 32'd4);
        send_item(32'd45, 32'd30);
        idle_cycles(3);
        send_item(32'd100, 32'd100);
        send_item(32'hAAAA_AAAA, 32'h5555_5555);
        drain_unit();
    endtask

    // Runs a few items under the modulus extremes, a large modulus and the cases
    // that wrap at 32 bits or reduce everything to zero.
    task automatic test_modulus_extremes();
        logic [31:0] settings[5];
        settings = '{32'd0, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'd1000000007};
        foreach (settings[k]) begin
            write_register(ADDR_MODULUS[0], settings[k]);
            send_item(32'd90, 32'd60);
            send_item(32'd1, 32'd7);
            send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
            random_burst_run(3);
            drain_unit();
        end
    endtask

    // A write to the unused address must leave the modulus alone.
    task automatic test_unused_address();
        write_register(ADDR_MODULUS[0], 32'd97);
        write_register(1'b1, 32'd5);
        send_item(32'd200, 32'd150);
        send_item(32'd77, 32'd7);
        drain_unit();
    endtask

    // The bulk of the random items, spread over several modulus settings.
    // In each phase the sender holds off until all results are in after each run.
    task automatic test_random_items();
        logic [31:0] setting;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: setting = MODULUS_RESET;
                1: setting = 32'hFFFF_FFFF;
                2: setting = 32'd2;
                3: setting = 32'd0;
                default: setting = $urandom_range(2, 32'hFFFF_FFFF);
            endcase
            write_register(ADDR_MODULUS[0], setting);
            random_burst_run(RANDOM_ITEMS / 12);
            drain_unit();
            idle_cycles($urandom_range(1, 20));
            random_burst_run(RANDOM_ITEMS / 12);
            drain_unit();
        end
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        modulus_shadow = MODULUS_RESET;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_first_index = '0;
        i_second_index = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 1'b0;
        pwdata = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_indices();
        test_modulus_extremes();
        test_unused_address();
        test_random_items();
        drain_unit();

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
